[hdl/pctc_pkg.sv]
package pctc_pkg;

    // Channel and configuration widths
    localparam int D_W        = 24;
    localparam int P_W        = 32;
    localparam int T_W        = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COEFF_W    = 16;

    // Internal datapath widths, sized to the value ranges of each term
    localparam int DT_W    = 25;  // dT, signed
    localparam int CP_W    = 42;  // coefficient times dT, signed
    localparam int SQ_W    = 48;  // dT squared, unsigned
    localparam int SENS_W  = 35;  // first-order sensitivity, signed
    localparam int OFF_W   = 36;  // first-order offset, signed
    localparam int TIL_W   = 17;  // cold-branch temperature correction
    localparam int TIH_W   = 12;  // warm-branch temperature correction
    localparam int DSQ_W   = 34;  // squared temperature deviations, unsigned
    localparam int OFFI_W  = 38;  // offset correction, unsigned
    localparam int SENSI_W = 37;  // sensitivity correction, unsigned
    localparam int OFF2_W  = 40;  // corrected offset, signed
    localparam int SENS2_W = 39;  // corrected sensitivity, signed
    localparam int LO_W    = 20;  // low slice of SENS2 for the split multiply
    localparam int HI_W    = SENS2_W - LO_W;
    localparam int PP_W    = 44;  // partial products
    localparam int MUL_W   = 63;  // D1 times SENS2, signed
    localparam int Q_W     = 43;  // scaled product minus offset, signed

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TREF      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS = 3'd5;

    // Temperature thresholds in 0.01 degC
    localparam logic signed [T_W-1:0] TEMP_REF   = 19'sd2000;
    localparam logic signed [T_W-1:0] TEMP_FROST = -19'sd1500;

    typedef struct packed {
        logic [COEFF_W-1:0] sens;
        logic [COEFF_W-1:0] offset;
        logic [COEFF_W-1:0] sens_tc;
        logic [COEFF_W-1:0] offset_tc;
        logic [COEFF_W-1:0] tref;
        logic [COEFF_W-1:0] temp_sens;
    } t_coeffs;

    typedef struct packed {
        logic        [D_W-1:0]    d1;
        logic signed [SENS_W-1:0] sens;
        logic signed [OFF_W-1:0]  off;
        logic signed [T_W-1:0]    temp;
        logic        [TIL_W-1:0]  ti_lo;
        logic        [TIH_W-1:0]  ti_hi;
    } t_first;

    typedef struct packed {
        logic        [D_W-1:0]     d1;
        logic signed [OFF2_W-1:0]  off2;
        logic signed [SENS2_W-1:0] sens2;
        logic signed [T_W-1:0]     temp2;
    } t_second;

    // Signed division by 2^k that truncates toward zero
    function automatic logic signed [63:0] div_trunc_pow2(input logic signed [63:0] x,
                                                          input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

[hdl/pctc_in_if.sv]
interface pctc_in_if import pctc_pkg::*;;
    logic           valid;
    logic           ready;
    logic [D_W-1:0] raw_pressure;
    logic [D_W-1:0] raw_temperature;

    modport source(output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

[hdl/pctc_out_if.sv]
interface pctc_out_if import pctc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic signed [P_W-1:0] pressure_decimbar;
    logic signed [T_W-1:0] temperature_centideg;

    modport source(output valid, output pressure_decimbar, output temperature_centideg,
                   input ready);
    modport sink(input valid, input pressure_decimbar, input temperature_centideg,
                 output ready);
endinterface

[hdl/pctc_first.sv]
module pctc_first import pctc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_coeffs        i_coeffs,
    input  logic           i_vld,
    output logic           o_rdy,
    input  logic [D_W-1:0] i_d1,
    input  logic [D_W-1:0] i_d2,
    output logic           o_vld,
    input  logic           i_rdy,
    output t_first         o_data
);

    localparam int NSTG = 3;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   adv;

    // stage 1
    logic        [D_W-1:0]  r_d1_s1;
    logic signed [DT_W-1:0] r_dt;
    logic signed [DT_W-1:0] n_dt;
    // stage 2
    logic        [D_W-1:0]  r_d1_s2;
    logic signed [CP_W-1:0] r_p_sens;
    logic signed [CP_W-1:0] r_p_off;
    logic signed [CP_W-1:0] r_p_temp;
    logic        [SQ_W-1:0] r_dt_sq;
    logic signed [CP_W-1:0] n_p_sens;
    logic signed [CP_W-1:0] n_p_off;
    logic signed [CP_W-1:0] n_p_temp;
    logic signed [2*DT_W-1:0] n_dt_sq;
    // stage 3
    t_first               r_out;
    t_first               n_out;
    logic [SQ_W+1:0]      dt_sq3;

    always_comb begin
        adv[NSTG] = i_rdy;
        for (int s = NSTG - 1; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_rdy  = adv[0];
    assign o_vld  = r_vld[NSTG-1];
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            for (int s = 1; s < NSTG; s++) begin
                if (adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign n_dt = $signed({1'b0, i_d2}) - $signed({1'b0, i_coeffs.tref, 8'd0});

    assign n_p_sens = $signed({1'b0, i_coeffs.sens_tc}) * r_dt;
    assign n_p_off  = $signed({1'b0, i_coeffs.offset_tc}) * r_dt;
    assign n_p_temp = $signed({1'b0, i_coeffs.temp_sens}) * r_dt;
    assign n_dt_sq  = r_dt * r_dt;

    // 3 * dT^2 for the cold branch
    assign dt_sq3 = ((SQ_W+2)'(r_dt_sq) << 1) + (SQ_W+2)'(r_dt_sq);

    always_comb begin
        n_out.d1    = r_d1_s2;
        n_out.sens  = $signed({4'd0, i_coeffs.sens, 15'd0})
                    + SENS_W'(div_trunc_pow2(64'(r_p_sens), 8));
        n_out.off   = $signed({4'd0, i_coeffs.offset, 16'd0})
                    + OFF_W'(div_trunc_pow2(64'(r_p_off), 7));
        n_out.temp  = TEMP_REF + T_W'(div_trunc_pow2(64'(r_p_temp), 23));
        n_out.ti_lo = dt_sq3[SQ_W+1:33];
        n_out.ti_hi = r_dt_sq[SQ_W-1:36];
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_d1_s1 <= i_d1;
            r_dt    <= n_dt;
        end
        if (adv[1]) begin
            r_d1_s2  <= r_d1_s1;
            r_p_sens <= n_p_sens;
            r_p_off  <= n_p_off;
            r_p_temp <= n_p_temp;
            r_dt_sq  <= n_dt_sq[SQ_W-1:0];
        end
        if (adv[2]) begin
            r_out <= n_out;
        end
    end

    a_ti_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (TIL_W'(r_out.ti_hi) <= r_out.ti_lo))
        else $error("warm correction exceeds cold correction");

endmodule

[hdl/pctc_second.sv]
module pctc_second import pctc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    output logic    o_rdy,
    input  t_first  i_data,
    output logic    o_vld,
    input  logic    i_rdy,
    output t_second o_data
);

    localparam int NSTG = 3;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   adv;

    // stage 4
    logic                     r_cold;
    logic                     r_frost;
    logic        [DSQ_W-1:0]  r_dev_sq;
    logic        [DSQ_W-1:0]  r_low_sq;
    logic        [D_W-1:0]    r_d1_s4;
    logic signed [SENS_W-1:0] r_sens_s4;
    logic signed [OFF_W-1:0]  r_off_s4;
    logic signed [T_W-1:0]    r_temp2_s4;
    logic signed [T_W-1:0]    dev;
    logic signed [T_W-1:0]    low;
    logic signed [2*T_W-1:0]  n_dev_sq;
    logic signed [2*T_W-1:0]  n_low_sq;
    logic        [TIL_W-1:0]  ti;
    // stage 5
    logic                     r_cold_s5;
    logic        [OFFI_W-1:0]  r_offi;
    logic        [SENSI_W-1:0] r_sensi;
    logic        [D_W-1:0]    r_d1_s5;
    logic signed [SENS_W-1:0] r_sens_s5;
    logic signed [OFF_W-1:0]  r_off_s5;
    logic signed [T_W-1:0]    r_temp2_s5;
    logic        [DSQ_W+1:0]  dev3;
    logic        [DSQ_W+2:0]  dev5;
    logic        [DSQ_W+2:0]  low7;
    logic        [OFFI_W-1:0]  n_offi;
    logic        [SENSI_W-1:0] n_sensi;
    // stage 6
    t_second                  r_out;

    always_comb begin
        adv[NSTG] = i_rdy;
        for (int s = NSTG - 1; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_rdy  = adv[0];
    assign o_vld  = r_vld[NSTG-1];
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            for (int s = 1; s < NSTG; s++) begin
                if (adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Deviations from 20 degC and from -15 degC; their sign gives the branch
    assign dev      = i_data.temp - TEMP_REF;
    assign low      = i_data.temp - TEMP_FROST;
    assign n_dev_sq = dev * dev;
    assign n_low_sq = low * low;
    assign ti       = dev[T_W-1] ? i_data.ti_lo : TIL_W'(i_data.ti_hi);

    assign dev3 = ((DSQ_W+2)'(r_dev_sq) << 1) + (DSQ_W+2)'(r_dev_sq);
    assign dev5 = ((DSQ_W+3)'(r_dev_sq) << 2) + (DSQ_W+3)'(r_dev_sq);
    assign low7 = ((DSQ_W+3)'(r_low_sq) << 3) - (DSQ_W+3)'(r_low_sq);

    always_comb begin
        if (r_cold) begin
            n_offi  = OFFI_W'(dev3[DSQ_W+1:1]) + (r_frost ? OFFI_W'(low7) : '0);
            n_sensi = SENSI_W'(dev5[DSQ_W+2:3])
                    + (r_frost ? SENSI_W'({r_low_sq, 2'd0}) : '0);
        end else begin
            n_offi  = OFFI_W'(r_dev_sq[DSQ_W-1:4]);
            n_sensi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_cold     <= dev[T_W-1];
            r_frost    <= low[T_W-1];
            r_dev_sq   <= n_dev_sq[DSQ_W-1:0];
            r_low_sq   <= n_low_sq[DSQ_W-1:0];
            r_d1_s4    <= i_data.d1;
            r_sens_s4  <= i_data.sens;
            r_off_s4   <= i_data.off;
            r_temp2_s4 <= i_data.temp - $signed(T_W'(ti));
        end
        if (adv[1]) begin
            r_cold_s5  <= r_cold;
            r_offi     <= n_offi;
            r_sensi    <= n_sensi;
            r_d1_s5    <= r_d1_s4;
            r_sens_s5  <= r_sens_s4;
            r_off_s5   <= r_off_s4;
            r_temp2_s5 <= r_temp2_s4;
        end
        if (adv[2]) begin
            r_out.d1    <= r_d1_s5;
            r_out.off2  <= OFF2_W'(r_off_s5) - $signed(OFF2_W'(r_offi));
            r_out.sens2 <= SENS2_W'(r_sens_s5) - $signed(SENS2_W'(r_sensi));
            r_out.temp2 <= r_temp2_s5;
        end
    end

    a_warm_no_sensi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !r_cold_s5) |-> (r_sensi == '0))
        else $error("sensitivity correction applied above 20 degC");

    a_frost_is_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && r_frost) |-> r_cold)
        else $error("below -15 degC flag without below 20 degC flag");

endmodule

[hdl/pctc_press.sv]
module pctc_press import pctc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    output logic                  o_rdy,
    input  t_second               i_data,
    output logic                  o_vld,
    input  logic                  i_rdy,
    output logic signed [P_W-1:0] o_pressure,
    output logic signed [T_W-1:0] o_temperature
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   adv;

    // temperature rides along every stage; the offset only until it is subtracted
    logic signed [T_W-1:0]    r_temp [NSTG];
    logic signed [OFF2_W-1:0] r_off2 [NSTG-2];

    logic        [PP_W-1:0]  r_pp_lo;
    logic signed [PP_W-1:0]  r_pp_hi;
    logic        [PP_W-1:0]  n_pp_lo;
    logic signed [PP_W-1:0]  n_pp_hi;
    logic signed [MUL_W-1:0] r_prod;
    logic signed [MUL_W-1:0] n_prod;
    logic signed [Q_W-1:0]   r_q;
    logic signed [P_W-1:0]   r_p;

    always_comb begin
        adv[NSTG] = i_rdy;
        for (int s = NSTG - 1; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_rdy         = adv[0];
    assign o_vld         = r_vld[NSTG-1];
    assign o_pressure    = r_p;
    assign o_temperature = r_temp[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            for (int s = 1; s < NSTG; s++) begin
                if (adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // D1 * SENS2 split into a low unsigned slice and a high signed slice
    assign n_pp_lo = i_data.d1 * i_data.sens2[LO_W-1:0];
    assign n_pp_hi = $signed({1'b0, i_data.d1}) * $signed(i_data.sens2[SENS2_W-1:LO_W]);
    assign n_prod  = (MUL_W'(r_pp_hi) <<< LO_W) + $signed(MUL_W'(r_pp_lo));

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_pp_lo   <= n_pp_lo;
            r_pp_hi   <= n_pp_hi;
            r_off2[0] <= i_data.off2;
            r_temp[0] <= i_data.temp2;
        end
        if (adv[1]) begin
            r_prod    <= n_prod;
            r_off2[1] <= r_off2[0];
            r_temp[1] <= r_temp[0];
        end
        if (adv[2]) begin
            r_q       <= Q_W'(div_trunc_pow2(64'(r_prod), 21)) - Q_W'(r_off2[1]);
            r_temp[2] <= r_temp[1];
        end
        if (adv[3]) begin
            r_p       <= P_W'(div_trunc_pow2(64'(r_q), 13));
            r_temp[3] <= r_temp[2];
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !adv[1]) |=> r_vld[1])
        else $error("stalled product stage lost its item");

endmodule

[hdl/pressure_temp_compensation_core.sv]
// Second-order pressure and temperature compensation for a 30 bar piezo-resistive
// sensor. Each input item is a pair of raw 24-bit conversions (D1 pressure, D2
// temperature); each result item carries pressure in 0.1 mbar (32-bit, wraps like a
// C cast) and temperature in 0.01 degC (19-bit). The six calibration words C1..C6
// sit at register indexes 0..5 of the write port; other indexes are ignored, and
// they should be written only while no item is in flight. The datapath is a
// ten-stage pipeline: an item enters every cycle unless results back up from a
// stalled output and fill it, the depth being set by the chain of registered
// multipliers (coefficient products, squared deviations, then a split 24 x 39 bit
// product) and the round-toward-zero scaling that follows each of them.
module pressure_temp_compensation_core import pctc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pctc_in_if.sink               i_in,
    pctc_out_if.source            o_out,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_coeffs r_coeffs;

    logic    first_vld;
    logic    first_rdy;
    t_first  first_data;
    logic    second_vld;
    logic    second_rdy;
    t_second second_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_SENS:      r_coeffs.sens      <= i_cfg_data;
                REG_OFFSET:    r_coeffs.offset    <= i_cfg_data;
                REG_SENS_TC:   r_coeffs.sens_tc   <= i_cfg_data;
                REG_OFFSET_TC: r_coeffs.offset_tc <= i_cfg_data;
                REG_TREF:      r_coeffs.tref      <= i_cfg_data;
                REG_TEMP_SENS: r_coeffs.temp_sens <= i_cfg_data;
                default:       r_coeffs           <= r_coeffs;
            endcase
        end
    end

    pctc_first u_first (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coeffs (r_coeffs),
        .i_vld    (i_in.valid),
        .o_rdy    (i_in.ready),
        .i_d1     (i_in.raw_pressure),
        .i_d2     (i_in.raw_temperature),
        .o_vld    (first_vld),
        .i_rdy    (first_rdy),
        .o_data   (first_data)
    );

    pctc_second u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (first_vld),
        .o_rdy   (first_rdy),
        .i_data  (first_data),
        .o_vld   (second_vld),
        .i_rdy   (second_rdy),
        .o_data  (second_data)
    );

    pctc_press u_press (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (second_vld),
        .o_rdy         (second_rdy),
        .i_data        (second_data),
        .o_vld         (o_out.valid),
        .i_rdy         (o_out.ready),
        .o_pressure    (o_out.pressure_decimbar),
        .o_temperature (o_out.temperature_centideg)
    );

endmodule

[tb/pctc_result_checker.sv]
module pctc_result_checker import pctc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pctc_in_if                    i_in,
    pctc_out_if                   i_out,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_REPORTS = 10;
    localparam longint TI_COLD_DIV = 64'sd8589934592;
    localparam longint TI_WARM_DIV = 64'sd137438953472;

    typedef struct packed {
        logic signed [P_W-1:0] pressure;
        logic signed [T_W-1:0] temperature;
    } t_reading;

    t_coeffs  coeffs;
    t_reading expected_readings[$];

    function automatic t_reading compensate_reading(logic [D_W-1:0] d1_raw,
                                                    logic [D_W-1:0] d2_raw,
                                                    t_coeffs c);
        longint   d1, d2, k_sens, k_off, k_sens_tc, k_off_tc, k_tref, k_temp_sens;
        longint   dt, sens, off, temp, dev, frost, ti, offi, sensi, p;
        t_reading r;
        d1          = d1_raw;
        d2          = d2_raw;
        k_sens      = c.sens;
        k_off       = c.offset;
        k_sens_tc   = c.sens_tc;
        k_off_tc    = c.offset_tc;
        k_tref      = c.tref;
        k_temp_sens = c.temp_sens;

        dt   = d2 - k_tref * 256;
        sens = k_sens * 32768 + (k_sens_tc * dt) / 256;
        off  = k_off * 65536 + (k_off_tc * dt) / 128;
        temp = TEMP_REF + (dt * k_temp_sens) / 8388608;
        dev  = temp - TEMP_REF;

        if (temp < TEMP_REF) begin
            ti    = (3 * dt * dt) / TI_COLD_DIV;
            offi  = (3 * dev * dev) / 2;
            sensi = (5 * dev * dev) / 8;
            // extra correction below the frost threshold
            if (temp < TEMP_FROST) begin
                frost = temp - TEMP_FROST;
                offi  = offi + 7 * frost * frost;
                sensi = sensi + 4 * frost * frost;
            end
        end else begin
            ti    = (2 * dt * dt) / TI_WARM_DIV;
            offi  = (dev * dev) / 16;
            sensi = 0;
        end

        p    = ((d1 * (sens - sensi)) / 2097152 - (off - offi)) / 8192;
        temp = temp - ti;
        r.pressure    = p[P_W-1:0];
        r.temperature = temp[T_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            coeffs = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_SENS:      coeffs.sens      = i_cfg_data;
                    REG_OFFSET:    coeffs.offset    = i_cfg_data;
                    REG_SENS_TC:   coeffs.sens_tc   = i_cfg_data;
                    REG_OFFSET_TC: coeffs.offset_tc = i_cfg_data;
                    REG_TREF:      coeffs.tref      = i_cfg_data;
                    REG_TEMP_SENS: coeffs.temp_sens = i_cfg_data;
                    default: ;
                endcase
            end

            // compare before pushing, so a stray item cannot match this edge's input
            if (i_out.valid && i_out.ready) begin
                if (expected_readings.size() == 0) begin
                    if (o_mismatches < MAX_REPORTS)
                        $display("%0t: unexpected item p=%0d t=%0d", $realtime,
                                 i_out.pressure_decimbar, i_out.temperature_centideg);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = expected_readings.pop_front();
                    if (i_out.pressure_decimbar !== want.pressure ||
                        i_out.temperature_centideg !== want.temperature) begin
                        if (o_mismatches < MAX_REPORTS)
                            $display("%0t: mismatch, expected p=%0d t=%0d, got p=%0d t=%0d",
                                     $realtime, want.pressure, want.temperature,
                                     i_out.pressure_decimbar, i_out.temperature_centideg);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end

            if (i_in.valid && i_in.ready)
                expected_readings.push_back(compensate_reading(i_in.raw_pressure,
                                                               i_in.raw_temperature, coeffs));
        end
        o_pending = expected_readings.size();
    end

endmodule

[tb/pressure_temp_compensation_core_tb.sv]
module pressure_temp_compensation_core_tb import pctc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     IDLE_LIMIT      = 1000;
    localparam int     DRAIN_CYCLES    = 12;
    localparam int     RESET_CYCLES    = 8;
    localparam int     ITEMS_PER_PHASE = 60;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     PAUSE_PHASE     = 4;
    localparam longint RAW_TOP         = (64'sd1 <<< D_W) - 64'sd1;

    localparam logic [D_W-1:0]       RAW_MAX      = '1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam t_coeffs COEFF_TYPICAL = '{sens: 16'd34982, offset: 16'd36352,
                                          sens_tc: 16'd20328, offset_tc: 16'd22354,
                                          tref: 16'd26646, temp_sens: 16'd26146};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int      mismatches;
    int      pending;
    int      idle_cycles;
    int      gap_pct;
    bit      quiet;
    t_coeffs coeffs;

    pctc_in_if  in_ch();
    pctc_out_if out_ch();

    pressure_temp_compensation_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pctc_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr_en || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("pressure_temp_compensation_core test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Raw temperature conversion that lands the first-order temperature on target
    function automatic logic [D_W-1:0] raw_temp_for(int target, t_coeffs c);
        longint ts, d2;
        ts = c.temp_sens;
        d2 = c.tref;
        d2 = d2 * 256;
        if (ts != 0)
            d2 = d2 - ((2000 - target) * 64'sd8388608 + ts - 1) / ts;
        if (d2 < 0)
            d2 = 0;
        if (d2 > RAW_TOP)
            d2 = RAW_TOP;
        return d2[D_W-1:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_idx   = idx;
        cfg_data  = data;
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic program_coeffs(t_coeffs c);
        write_reg(REG_SENS, c.sens);
        write_reg(REG_OFFSET, c.offset);
        write_reg(REG_SENS_TC, c.sens_tc);
        write_reg(REG_OFFSET_TC, c.offset_tc);
        write_reg(REG_TREF, c.tref);
        write_reg(REG_TEMP_SENS, c.temp_sens);
        // unmapped index: must leave the calibration untouched
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  CFG_DATA_W'($urandom_range(0, 65535)));
        coeffs = c;
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_conversion(logic [D_W-1:0] d1, logic [D_W-1:0] d2);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid           = 1'b1;
        in_ch.raw_pressure    = d1;
        in_ch.raw_temperature = d2;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result back-pressure
    initial begin
        int stall_left;
        int stall_pct;
        int window;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        stall_pct    = 0;
        window       = 0;
        forever begin
            @(negedge i_clk);
            if (window == 0) begin
                window    = 64;
                stall_pct = $urandom_range(0, 2) * 15;
            end
            window = window - 1;
            if (quiet) begin
                out_ch.ready = 1'b1;
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left   = stall_left - 1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                out_ch.ready = 1'b0;
                stall_left   = $urandom_range(0, 2);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    initial begin
        logic [D_W-1:0] d1;
        logic [D_W-1:0] d2;
        logic [D_W-1:0] corner_d2 [8];
        longint         centre;
        longint         tmp;
        t_coeffs        c;

        in_ch.valid           = 1'b0;
        in_ch.raw_pressure    = '0;
        in_ch.raw_temperature = '0;
        cfg_wr_en             = 1'b0;
        cfg_idx               = REG_SENS;
        cfg_data              = '0;
        quiet                 = 1'b0;
        gap_pct               = 15;
        coeffs                = '0;
        i_rst_n               = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // calibration still all zero out of reset
        send_conversion('0, '0);
        send_conversion(RAW_MAX, RAW_MAX);
        send_conversion('0, RAW_MAX);
        send_conversion(RAW_MAX, '0);

        drain();
        program_coeffs(COEFF_TYPICAL);
        // warm/cold boundary, the frost threshold, and the raw extremes
        corner_d2 = '{'0, RAW_MAX,
                      raw_temp_for(2000, coeffs), D_W'(raw_temp_for(2000, coeffs) - 1),
                      D_W'(raw_temp_for(2000, coeffs) + 1), raw_temp_for(1999, coeffs),
                      raw_temp_for(-1500, coeffs), raw_temp_for(-1501, coeffs)};
        foreach (corner_d2[k]) begin
            send_conversion(RAW_MAX, corner_d2[k]);
            send_conversion('0, corner_d2[k]);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: c = '1;
                1: c = COEFF_TYPICAL;
                2: c = '0;
                3: begin
                    for (int r = 0; r < 6; r++)
                        c[r*COEFF_W +: COEFF_W] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                end
                default: c = t_coeffs'({$urandom, $urandom, $urandom});
            endcase
            // final stretch runs without idling on either side
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            drain();
            program_coeffs(c);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0)
                    gap_pct = $urandom_range(0, 2) * 15;
                if (phase == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) begin
                    // hold off until the pipeline has emptied
                    in_ch.valid = 1'b0;
                    while (pending != 0)
                        @(negedge i_clk);
                end
                centre = coeffs.tref;
                centre = centre * 256;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: d2 = D_W'($urandom);
                    6, 7: begin
                        tmp = centre + longint'($urandom_range(0, 2097152)) - 1048576;
                        if (tmp < 0)
                            tmp = 0;
                        if (tmp > RAW_TOP)
                            tmp = RAW_TOP;
                        d2 = tmp[D_W-1:0];
                    end
                    8: d2 = $urandom_range(0, 1) ? RAW_MAX : '0;
                    default: d2 = D_W'($urandom_range(0, int'(centre)));
                endcase
                if ($urandom_range(0, 15) == 0)
                    d1 = $urandom_range(0, 1) ? RAW_MAX : '0;
                else
                    d1 = D_W'($urandom);
                send_conversion(d1, d2);
            end
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("pressure_temp_compensation_core test passed");
        else
            $display("pressure_temp_compensation_core test failed");
        $finish;
    end

endmodule
